### sv/imheq_pkg.sv
// Package: sizes, operation and status codes for the expiry heap.
`timescale 1ns / 1ps
package imheq_pkg;
    localparam int CAPACITY     = 1024;
    localparam int HANDLE_COUNT = 1024;
    localparam int KEY_BITS     = 48;
    localparam int SLOT_W       = $clog2(CAPACITY);
    localparam int HND_W        = $clog2(HANDLE_COUNT);
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [HND_W-1:0]    hnd;
    } slot_t;
endpackage

### sv/indexed_min_heap_expiry_queue.sv
// Top level: indexed binary min-heap of (expiry, handle) pairs with a handle position table.
`timescale 1ns / 1ps
// Sequencing: an insert climbs level by level; a pop moves the last entry to the root and
//   descends level by level; a remove ends early if stale or at the last slot, else sifts.
//   The single-port heap RAM sets the pace.
// Throughput: one item at a time; ready is low from acceptance until the result is taken.
// Reset: asynchronous, active low; a clearing pass then sweeps every entry of the position
//   table before the first item is accepted. Heap RAM contents are not reset.
module indexed_min_heap_expiry_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [9:0]  handle,
    input  logic [47:0] expiry_key,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [9:0]  popped_handle,
    output logic [47:0] popped_expiry,
    output logic [10:0] entry_count
);
    localparam int SW = imheq_pkg::SLOT_W;
    localparam int HW = imheq_pkg::HND_W;
    localparam int CW = imheq_pkg::CNT_W;
    localparam int KB = imheq_pkg::KEY_BITS;

    // Sequencer states
    localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_INS = 5'd2,
                           S_UPP   = 5'd3,  S_UPRD = 5'd4,  S_UPW1 = 5'd5,
                           S_POPR  = 5'd6,  S_POPL = 5'd7,  S_DNL = 5'd8,
                           S_DNR   = 5'd9,  S_DNCMP = 5'd10, S_DNW1 = 5'd11,
                           S_DNW2  = 5'd12, S_RMCL = 5'd13, S_RMP = 5'd14,
                           S_RMS   = 5'd15, S_RML = 5'd16,  S_RMPR = 5'd17,
                           S_UPRM  = 5'd18, S_UPRC = 5'd19, S_DONE = 5'd20,
                           S_OUT   = 5'd21;

    // Heap RAM: one port, registered read
    imheq_pkg::slot_t heap_mem [imheq_pkg::CAPACITY];
    imheq_pkg::slot_t hrd_reg;
    logic             h_we;
    logic [SW-1:0]    h_addr;
    imheq_pkg::slot_t h_wd;
    always_ff @(posedge clk)
    begin
        if (h_we)
            heap_mem[h_addr] <= h_wd;
        hrd_reg <= heap_mem[h_addr];
    end

    // Position table RAM: {present, slot}
    logic [SW:0]   pos_mem [imheq_pkg::HANDLE_COUNT];
    logic [SW:0]   prd_reg;
    logic          p_we;
    logic [HW-1:0] p_addr;
    logic [SW:0]   p_wd;
    always_ff @(posedge clk)
    begin
        if (p_we)
            pos_mem[p_addr] <= p_wd;
        prd_reg <= pos_mem[p_addr];
    end

    logic [4:0]          state_reg, state_next;
    logic [CW-1:0]       occ_reg, occ_next;
    logic [SW-1:0]       i_reg, i_next;      // current slot of moving entry
    logic [SW-1:0]       j_reg, j_next;      // partner slot
    imheq_pkg::slot_t    mv_reg, mv_next;    // moving entry
    imheq_pkg::slot_t    bst_reg, bst_next;  // best child / parent entry
    imheq_pkg::slot_t    top_reg, top_next;  // popped/removed entry
    logic [HW-1:0]       clr_reg, clr_next;
    logic [1:0]          st_reg, st_next;
    logic                rm_reg, rm_next;    // operation is a remove
    logic                ov_reg, ov_next;

    // Shared compare unit: a <= b on keys
    logic [KB-1:0] cmp_a, cmp_b;
    logic          cmp_le;
    assign cmp_le = (cmp_a <= cmp_b);

    logic [SW:0]  lchild;
    assign lchild = {i_reg, 1'b1};
    logic [SW-1:0] parent;
    assign parent = SW'((i_reg - 1'b1) >> 1);

    always_comb
    begin
        state_next = state_reg;
        occ_next = occ_reg; i_next = i_reg; j_next = j_reg;
        mv_next = mv_reg; bst_next = bst_reg; top_next = top_reg;
        clr_next = clr_reg; st_next = st_reg; rm_next = rm_reg; ov_next = ov_reg;
        h_we = 1'b0; h_addr = i_reg; h_wd = mv_reg;
        p_we = 1'b0; p_addr = mv_reg.hnd; p_wd = {1'b1, i_reg};
        cmp_a = mv_reg.key; cmp_b = hrd_reg.key;
        case (state_reg)
            S_CLEAR:
            begin
                p_we = 1'b1; p_addr = clr_reg; p_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == HW'(imheq_pkg::HANDLE_COUNT - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    st_next = imheq_pkg::ST_OK;
                    top_next = '0;
                    rm_next = 1'b0;
                    mv_next.key = expiry_key[KB-1:0];
                    mv_next.hnd = handle;
                    p_addr = handle;
                    h_addr = '0;
                    case (kind)
                        imheq_pkg::KIND_INSERT:
                            if (occ_reg == CW'(imheq_pkg::CAPACITY))
                            begin
                                st_next = imheq_pkg::ST_FULL; state_next = S_DONE;
                            end
                            else
                            begin
                                i_next = SW'(occ_reg);
                                occ_next = occ_reg + 1'b1;
                                state_next = S_INS;
                            end
                        imheq_pkg::KIND_POP:
                            if (occ_reg == '0)
                            begin
                                st_next = imheq_pkg::ST_EMPTY; state_next = S_DONE;
                            end
                            else
                                state_next = S_POPR;
                        imheq_pkg::KIND_REMOVE:
                        begin
                            rm_next = 1'b1; state_next = S_RMP;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_INS:
            begin
                h_we = 1'b1; p_we = 1'b1;
                state_next = S_UPP;
            end
            // sift up: read parent, compare, swap
            S_UPP:
            begin
                if (i_reg == '0)
                    state_next = S_DONE;
                else
                begin
                    h_addr = parent; j_next = parent; state_next = S_UPRD;
                end
            end
            S_UPRD:
            begin
                if (cmp_le)
                begin
                    bst_next = hrd_reg;
                    h_we = 1'b1; h_addr = j_reg; h_wd = mv_reg;
                    p_we = 1'b1; p_addr = hrd_reg.hnd; p_wd = {1'b1, i_reg};
                    state_next = S_UPW1;
                end
                else
                    state_next = S_DONE;
            end
            S_UPW1:
            begin
                h_we = 1'b1; h_addr = i_reg; h_wd = bst_reg;
                p_we = 1'b1; p_addr = mv_reg.hnd; p_wd = {1'b1, j_reg};
                i_next = j_reg;
                state_next = S_UPP;
            end
            // pop: root came in at acceptance, read the last entry
            S_POPR:
            begin
                top_next = hrd_reg; // root
                h_addr = SW'(occ_reg - 1'b1);
                state_next = S_POPL;
            end
            S_POPL:
            begin
                // hrd_reg now holds the last entry; move it to the root
                mv_next = hrd_reg;
                i_next = '0;
                occ_next = occ_reg - 1'b1;
                h_we = 1'b1; h_addr = '0; h_wd = hrd_reg;
                p_we = 1'b1; p_addr = hrd_reg.hnd; p_wd = {1'b1, SW'(0)};
                state_next = S_DNL;
            end
            // sift down from i with entry mv
            S_DNL:
            begin
                bst_next = mv_reg; j_next = i_reg;
                if (lchild < (SW+1)'(occ_reg))
                begin
                    h_addr = lchild[SW-1:0]; state_next = S_DNR;
                end
                else
                    state_next = S_RMCL;
            end
            S_DNR:
            begin
                // left child data; fetch the right child
                cmp_a = hrd_reg.key; cmp_b = mv_reg.key;
                if (cmp_le)
                begin
                    bst_next = hrd_reg; j_next = lchild[SW-1:0];
                end
                h_addr = SW'(lchild + 1'b1);
                state_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                cmp_a = hrd_reg.key; cmp_b = bst_reg.key;
                if ((lchild + 1'b1) < (SW+1)'(occ_reg) && cmp_le)
                begin
                    bst_next = hrd_reg; j_next = SW'(lchild + 1'b1);
                    state_next = S_DNW1;
                end
                else if (j_reg == i_reg)
                    state_next = S_RMCL;
                else
                    state_next = S_DNW1;
            end
            S_DNW1:
            begin
                h_we = 1'b1; h_addr = i_reg; h_wd = bst_reg;
                p_we = 1'b1; p_addr = bst_reg.hnd; p_wd = {1'b1, i_reg};
                state_next = S_DNW2;
            end
            S_DNW2:
            begin
                h_we = 1'b1; h_addr = j_reg; h_wd = mv_reg;
                p_we = 1'b1; p_addr = mv_reg.hnd; p_wd = {1'b1, j_reg};
                i_next = j_reg;
                state_next = S_DNL;
            end
            // pop clears the present bit of the taken entry after sifting
            S_RMCL:
            begin
                if (!rm_reg)
                begin
                    p_we = 1'b1; p_addr = top_reg.hnd; p_wd = '0;
                end
                state_next = S_DONE;
            end
            // remove: read position, then slot, then last
            S_RMP:
            begin
                state_next = S_RMS;
            end
            S_RMS:
            begin
                i_next = prd_reg[SW-1:0];
                h_addr = prd_reg[SW-1:0];
                if (!prd_reg[SW] || (CW'(prd_reg[SW-1:0]) >= occ_reg))
                begin
                    st_next = imheq_pkg::ST_NOTFOUND; state_next = S_DONE;
                end
                else
                    state_next = S_RML;
            end
            S_RML:
            begin
                // hrd_reg: slot i content; fetch the last entry
                h_addr = SW'(occ_reg - 1'b1);
                if (hrd_reg.hnd != mv_reg.hnd)
                begin
                    st_next = imheq_pkg::ST_NOTFOUND; state_next = S_DONE;
                end
                else
                begin
                    top_next = hrd_reg;
                    occ_next = occ_reg - 1'b1;
                    if (CW'(i_reg) == occ_reg - 1'b1)
                    begin
                        // last slot: just drop it
                        p_we = 1'b1; p_addr = mv_reg.hnd; p_wd = '0;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_RMPR;
                end
            end
            S_RMPR:
            begin
                // hrd_reg: last entry; place it in slot i
                mv_next = hrd_reg;
                h_we = 1'b1; h_addr = i_reg; h_wd = hrd_reg;
                p_we = 1'b1; p_addr = hrd_reg.hnd; p_wd = {1'b1, i_reg};
                state_next = S_UPRM;
            end
            // clear the removed handle before sifting, then pick the direction
            S_UPRM:
            begin
                p_we = 1'b1; p_addr = top_reg.hnd; p_wd = '0;
                if (i_reg == '0)
                    state_next = S_DNL;
                else
                begin
                    h_addr = parent; j_next = parent; state_next = S_UPRC;
                end
            end
            S_UPRC:
            begin
                // hrd_reg: parent entry
                if (cmp_le)
                begin
                    bst_next = hrd_reg;
                    h_we = 1'b1; h_addr = j_reg; h_wd = mv_reg;
                    p_we = 1'b1; p_addr = hrd_reg.hnd; p_wd = {1'b1, i_reg};
                    state_next = S_UPW1;
                end
                else
                    state_next = S_DNL;
            end
            S_DONE:
            begin
                ov_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    ov_next = 1'b0; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            occ_reg   <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next; mv_reg <= mv_next;
        bst_reg <= bst_next; top_reg <= top_next; st_reg <= st_next; rm_reg <= rm_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = ov_reg;
    assign status        = st_reg;
    assign popped_handle = rm_reg ? '0 : top_reg.hnd;
    assign popped_expiry = rm_reg ? '0 : top_reg.key;
    assign entry_count   = occ_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(imheq_pkg::CAPACITY))
        else $error("occupancy exceeds capacity");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("ready while a result is held");
    a_occ_stable_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(occ_reg))
        else $error("count changed while result pending");
`endif
endmodule

### tb/indexed_min_heap_expiry_queue_tb.sv
// Testbench for the expiry heap queue: random and directed items against a heap predictor.
`timescale 1ns / 1ps

typedef struct {
    logic [1:0]  st;
    logic [9:0]  hnd;
    logic [47:0] key;
    logic [10:0] cnt;
} heap_result_t;

// Scoreboard: keeps a mirror of the heap and the position table and
// queues the result each accepted item should produce.
class expiry_heap_sb;
    logic [imheq_pkg::KEY_BITS-1:0] slot_key[imheq_pkg::CAPACITY];
    logic [imheq_pkg::HND_W-1:0]    slot_hnd[imheq_pkg::CAPACITY];
    int unsigned                    where[imheq_pkg::HANDLE_COUNT];
    bit                             live[imheq_pkg::HANDLE_COUNT];
    int unsigned                    count;
    heap_result_t                   expected_q[$];
    int                             mismatches;

    function new();
        count = 0;
        mismatches = 0;
        foreach (live[i]) live[i] = 1'b0;
        foreach (where[i]) where[i] = 0;
    endfunction

    function bit key_le(int unsigned a, int unsigned b);
        return slot_key[a] <= slot_key[b];
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
        logic [imheq_pkg::KEY_BITS-1:0] k;
        logic [imheq_pkg::HND_W-1:0]    h;
        k = slot_key[a]; h = slot_hnd[a];
        slot_key[a] = slot_key[b]; slot_hnd[a] = slot_hnd[b];
        slot_key[b] = k; slot_hnd[b] = h;
        where[slot_hnd[a]] = a; live[slot_hnd[a]] = 1'b1;
        where[slot_hnd[b]] = b; live[slot_hnd[b]] = 1'b1;
    endfunction

    function void climb(int unsigned i);
        while (i > 0 && key_le(i, (i - 1) / 2))
        begin
            swap_slots(i, (i - 1) / 2);
            i = (i - 1) / 2;
        end
    endfunction

    function void descend(int unsigned i);
        int unsigned best;
        forever
        begin
            best = i;
            if (2 * i + 1 < count && key_le(2 * i + 1, best)) best = 2 * i + 1;
            if (2 * i + 2 < count && key_le(2 * i + 2, best)) best = 2 * i + 2;
            if (best == i) return;
            swap_slots(i, best);
            i = best;
        end
    endfunction

    // Apply one accepted item and queue its expected result.
    function void note_item(logic [1:0] kind, logic [9:0] handle, logic [47:0] key_in);
        heap_result_t r;
        int unsigned i;
        logic [imheq_pkg::KEY_BITS-1:0] top_key;
        logic [imheq_pkg::HND_W-1:0]    top_hnd;
        r.st = imheq_pkg::ST_OK; r.hnd = '0; r.key = '0;
        case (kind)
            imheq_pkg::KIND_INSERT:
            begin
                if (count >= imheq_pkg::CAPACITY) r.st = imheq_pkg::ST_FULL;
                else
                begin
                    i = count;
                    count++;
                    slot_key[i] = key_in[imheq_pkg::KEY_BITS-1:0];
                    slot_hnd[i] = handle;
                    where[handle] = i;
                    live[handle] = 1'b1;
                    climb(i);
                end
            end
            imheq_pkg::KIND_POP:
            begin
                if (count == 0) r.st = imheq_pkg::ST_EMPTY;
                else
                begin
                    top_key = slot_key[0];
                    top_hnd = slot_hnd[0];
                    swap_slots(0, count - 1);
                    count--;
                    if (count > 0) descend(0);
                    live[top_hnd] = 1'b0;
                    r.hnd = top_hnd;
                    r.key = top_key;
                end
            end
            imheq_pkg::KIND_REMOVE:
            begin
                i = where[handle];
                if (!live[handle] || i >= count || slot_hnd[i] != handle)
                    r.st = imheq_pkg::ST_NOTFOUND;
                else if (i == count - 1)
                begin
                    count--;
                    live[handle] = 1'b0;
                end
                else
                begin
                    swap_slots(i, count - 1);
                    count--;
                    live[handle] = 1'b0;
                    if (i > 0 && key_le(i, (i - 1) / 2)) climb(i);
                    else descend(i);
                end
            end
            default: ;
        endcase
        r.cnt = 11'(count);
        expected_q.push_back(r);
    endfunction

    function void check_result(heap_result_t got);
        heap_result_t want;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: st=%0d hnd=%0d key=%0h cnt=%0d",
                         got.st, got.hnd, got.key, got.cnt);
            return;
        end
        want = expected_q.pop_front();
        if (got.st !== want.st || got.hnd !== want.hnd || got.key !== want.key
                || got.cnt !== want.cnt)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: want st=%0d hnd=%0d key=%0h cnt=%0d, ",
                          "got st=%0d hnd=%0d key=%0h cnt=%0d"},
                         want.st, want.hnd, want.key, want.cnt,
                         got.st, got.hnd, got.key, got.cnt);
        end
    endfunction
endclass

module indexed_min_heap_expiry_queue_tb;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int KIND_UNUSED    = 3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [9:0]  handle;
    logic [47:0] expiry_key;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [9:0]  popped_handle;
    logic [47:0] popped_expiry;
    logic [10:0] entry_count;

    expiry_heap_sb sb;
    int in_idle_pct;   // chance the sender holds off before an item
    int out_stall_pct; // chance the receiver drops ready in a cycle
    int quiet_cycles;

    indexed_min_heap_expiry_queue u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .handle       (handle),
        .expiry_key   (expiry_key),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_handle(popped_handle),
        .popped_expiry(popped_expiry),
        .entry_count  (entry_count)
    );

    always #6 clk = ~clk;

    // Receiver: ready drops at random per the current stall rate.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= out_stall_pct);

    // Result check: sampled values are the ones before this edge's updates.
    always @(posedge clk)
    begin
        heap_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.st = status; got.hnd = popped_handle;
            got.key = popped_expiry; got.cnt = entry_count;
            sb.check_result(got);
        end
    end

    // Watchdog: counts cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Drive one item and hold it until the block takes it.
    task automatic send_item(logic [1:0] k, logic [9:0] h, logic [47:0] e);
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        handle     <= h;
        expiry_key <= e;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(k, h, e);
    endtask

    // Hold off the sender until every queued result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    // Keys: mostly narrow so ties are common, sometimes full width.
    function automatic logic [47:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return 48'($urandom_range(15));
        if (sel < 8) return {16'h0, 32'($urandom)};
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Remove mostly targets a live entry; the rest may be stale.
    function automatic logic [9:0] pick_remove_handle();
        if (sb.count > 0 && $urandom_range(3) != 0)
            return sb.slot_hnd[$urandom_range(sb.count - 1)];
        return 10'($urandom_range(imheq_pkg::HANDLE_COUNT - 1));
    endfunction

    task automatic random_items(int n);
        int sel;
        repeat (n)
        begin
            sel = $urandom_range(99);
            if (sel < 45)
                send_item(imheq_pkg::KIND_INSERT,
                          10'($urandom_range(imheq_pkg::HANDLE_COUNT - 1)), pick_key());
            else if (sel < 70)
                send_item(imheq_pkg::KIND_POP, 10'($urandom), pick_key());
            else if (sel < 97)
                send_item(imheq_pkg::KIND_REMOVE, pick_remove_handle(), pick_key());
            else
                send_item(2'(KIND_UNUSED), 10'($urandom), pick_key());
        end
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = imheq_pkg::KIND_INSERT;
        handle = '0;
        expiry_key = '0;
        out_ready = 1'b0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty pop, stale remove, unused kind, key and handle extremes,
        // ties, removal of the last slot, removal from the middle, duplicate insert.
        send_item(imheq_pkg::KIND_POP, 10'h3ff, 48'hffff_ffff_ffff);
        send_item(imheq_pkg::KIND_REMOVE, 10'd5, '0);
        send_item(2'(KIND_UNUSED), 10'h3ff, 48'hffff_ffff_ffff);
        send_item(imheq_pkg::KIND_INSERT, 10'h3ff, 48'hffff_ffff_ffff);
        send_item(imheq_pkg::KIND_INSERT, 10'h000, 48'h0);
        send_item(imheq_pkg::KIND_INSERT, 10'd1, 48'd7);
        send_item(imheq_pkg::KIND_INSERT, 10'd2, 48'd7);
        send_item(imheq_pkg::KIND_INSERT, 10'd3, 48'd7);
        send_item(imheq_pkg::KIND_INSERT, 10'd4, 48'h8000_0000_0000);
        send_item(imheq_pkg::KIND_REMOVE, 10'd4, '0);
        send_item(imheq_pkg::KIND_REMOVE, 10'd1, '0);
        send_item(imheq_pkg::KIND_REMOVE, 10'd1, '0);
        send_item(imheq_pkg::KIND_INSERT, 10'd2, 48'd3);
        send_item(imheq_pkg::KIND_POP, '0, '0);
        send_item(imheq_pkg::KIND_POP, '0, '0);
        send_item(imheq_pkg::KIND_REMOVE, 10'd2, '0);
        send_item(imheq_pkg::KIND_POP, '0, '0);
        send_item(imheq_pkg::KIND_POP, '0, '0);
        send_item(imheq_pkg::KIND_POP, '0, '0);
        send_item(imheq_pkg::KIND_POP, '0, '0);

        // Phase 1: no idling.
        random_items(240);
        drain_results();

        // Phase 2: sender idles; fill to capacity, push past it, then mix.
        in_idle_pct = 62;
        while (sb.count < imheq_pkg::CAPACITY)
            send_item(imheq_pkg::KIND_INSERT,
                      10'($urandom_range(imheq_pkg::HANDLE_COUNT - 1)), pick_key());
        repeat (4) send_item(imheq_pkg::KIND_INSERT, 10'($urandom), pick_key());
        random_items(200);

        // Phase 3: receiver stalls.
        in_idle_pct = 0;
        out_stall_pct = 62;
        random_items(240);
        drain_results();

        // Phase 4: both idle lightly.
        in_idle_pct = 18;
        out_stall_pct = 18;
        random_items(240);

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
